// ----- design/cgvg_pkg.sv -----
package cgvg_pkg;

  // Default grid limits.
  localparam int MaxStacksDef = 64;
  localparam int MaxSlicesDef = 64;

  // CORDIC setup: Q4.30 datapath, fixed number of micro-rotations.
  localparam int CordicSteps = 16;
  localparam int CordicW     = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_STACKS = 2'd2,
    REG_SLICES = 2'd3
  } cfg_reg_t;

  // Arctangent of 2^-k as a fraction of a turn, scaled by 2^32.
  function automatic logic signed [CordicW-1:0] atan_turn(input logic [3:0] k);
    logic signed [CordicW-1:0] v;
    unique case (k)
      4'd0:  v = 34'sh020000000;
      4'd1:  v = 34'sh012E4051E;
      4'd2:  v = 34'sh009FB385B;
      4'd3:  v = 34'sh0051111D4;
      4'd4:  v = 34'sh0028B0D43;
      4'd5:  v = 34'sh00145D7E1;
      4'd6:  v = 34'sh000A2F61E;
      4'd7:  v = 34'sh000517C55;
      4'd8:  v = 34'sh00028BE53;
      4'd9:  v = 34'sh000145F2F;
      4'd10: v = 34'sh0000A2F98;
      4'd11: v = 34'sh0000517CC;
      4'd12: v = 34'sh000028BE6;
      4'd13: v = 34'sh0000145F3;
      4'd14: v = 34'sh00000A2FA;
      default: v = 34'sh00000517D;
    endcase
    return v;
  endfunction

  // Data carried by one CORDIC cell to the next.
  typedef struct packed {
    logic                      vld;
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
    logic [1:0]                quad;
    logic [14:0]               radius;
    logic signed [15:0]        pos_y;
    logic [16:0]               tex_s;
    logic [16:0]               tex_t;
    logic                      quad_valid;
    logic [12:0]               base;
    logic [12:0]               s_plus1;
  } cgvg_cell_t;

endpackage

// ----- design/cgvg_cell.sv -----
// One CORDIC micro-rotation; all side data rides along unchanged.
module cgvg_cell #(
  parameter int Step = 0
) (
  input  logic                cgvg_clk,
  input  logic                cgvg_rst_n,
  input  cgvg_pkg::cgvg_cell_t d_in,
  output cgvg_pkg::cgvg_cell_t d_out
);

  cgvg_pkg::cgvg_cell_t cell_r, cell_nxt;
  logic signed [cgvg_pkg::CordicW-1:0] dx, dy, at;

  // Rotate toward zero residual angle; reset drops the valid flag.
  always_comb begin
    dx = d_in.y >>> Step;
    dy = d_in.x >>> Step;
    at = cgvg_pkg::atan_turn(4'(Step));
    cell_nxt = d_in;
    cell_nxt.vld = d_in.vld & cgvg_rst_n;
    if (!d_in.z[cgvg_pkg::CordicW-1]) begin
      cell_nxt.x = d_in.x - dx;
      cell_nxt.y = d_in.y + dy;
      cell_nxt.z = d_in.z - at;
    end else begin
      cell_nxt.x = d_in.x + dx;
      cell_nxt.y = d_in.y - dy;
      cell_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge cgvg_clk) begin
    cell_r <= cell_nxt;
  end

  assign d_out = cell_r;

endmodule

// ----- design/cgvg_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module cgvg_divider #(
  parameter int NumW = 24,
  parameter int DenW = 8,
  parameter int Tag  = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  input  logic [Tag-1:0]  tag_in,
  output logic [NumW-1:0] quo,
  output logic [Tag-1:0]  tag_out
);

  localparam int RemW = DenW + 1;

  logic [NumW-1:0] num_r [NumW+1];
  logic [NumW-1:0] q_r   [NumW+1];
  logic [RemW-1:0] rem_r [NumW+1];
  logic [DenW-1:0] den_r [NumW+1];
  logic [Tag-1:0]  tag_r [NumW+1];

  always_comb begin
    num_r[0] = num;
    q_r[0]   = '0;
    rem_r[0] = '0;
    den_r[0] = den;
    tag_r[0] = tag_in;
  end

  // Each stage brings down one numerator bit and tries a subtract.
  for (genvar g = 0; g < NumW; g++) begin : g_stage
    logic [RemW:0]   trial;
    logic [RemW-1:0] rem_nxt;
    logic [NumW-1:0] q_nxt;
    always_comb begin
      trial = {rem_r[g], num_r[g][NumW-1-g]};
      if (trial >= {2'b00, den_r[g]}) begin
        rem_nxt = RemW'(trial - {2'b00, den_r[g]});
        q_nxt   = q_r[g] | (NumW'(1) << (NumW-1-g));
      end else begin
        rem_nxt = RemW'(trial);
        q_nxt   = q_r[g];
      end
    end
    // The tag carries the valid flag, so reset clears every stage of it at once.
    always_ff @(posedge clk) begin
      num_r[g+1] <= num_r[g];
      q_r[g+1]   <= q_nxt;
      rem_r[g+1] <= rem_nxt;
      den_r[g+1] <= den_r[g];
      tag_r[g+1] <= rst_n ? tag_r[g] : '0;
    end
  end

  assign quo     = q_r[NumW];
  assign tag_out = tag_r[NumW];

endmodule

// ----- design/cylinder_grid_vertex_generator.sv -----
// Channel  | Ports                                  | Handshake
// request  | in_stack_index, in_slice_index        | start high and busy low
// result   | out_pos_*, out_tex_*, out_tri*, valid | out_valid strobe, one cycle
// config   | cfg_we, cfg_index, cfg_data           | cfg_we high, no wait
// One request enters every cycle; busy is never raised. Each request passes through
// one input register, the 41-stage phase divider, 16 CORDIC cells and a
// three-stage output tail (quadrant map, radius multiply, round and saturate)
// before its result strobe.
// Reset (rst_n low, synchronous) empties the pipeline and restores the registers.
// The receiver cannot stall; results are not held.
module cylinder_grid_vertex_generator #(
  parameter int MaxStacks = cgvg_pkg::MaxStacksDef,
  parameter int MaxSlices = cgvg_pkg::MaxSlicesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [6:0]         in_stack_index,
  input  logic [6:0]         in_slice_index,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  output logic               out_valid,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic [16:0]        out_tex_s,
  output logic [16:0]        out_tex_t,
  output logic               out_quad_valid,
  output logic [12:0]        out_tri0_a,
  output logic [12:0]        out_tri0_b,
  output logic [12:0]        out_tri0_c,
  output logic [12:0]        out_tri1_a,
  output logic [12:0]        out_tri1_b,
  output logic [12:0]        out_tri1_c
);

  localparam int CW = cgvg_pkg::CordicW;
  // Phase numerator j*2^33+S needs 41 bits; all side quotients fit under it.
  localparam int NW = 41;
  localparam int DW = 8;

  logic [14:0] radius_r, height_r;
  logic [6:0]  stacks_r, slices_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 15'd256;
      height_r <= 15'd256;
      stacks_r <= 7'd8;
      slices_r <= 7'd16;
    end else if (cfg_we) begin
      unique case (cgvg_pkg::cfg_reg_t'(cfg_index))
        cgvg_pkg::REG_RADIUS: radius_r <= cfg_data;
        cgvg_pkg::REG_HEIGHT: height_r <= cfg_data;
        cgvg_pkg::REG_STACKS: stacks_r <= cfg_data[6:0];
        cgvg_pkg::REG_SLICES: slices_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Effective counts: zero acts as one, large values saturate.
  logic [10:0] t_eff, s_eff;
  always_comb begin
    if (stacks_r == 7'd0) t_eff = 11'd1;
    else if ({4'd0, stacks_r} > 11'(MaxStacks)) t_eff = 11'(MaxStacks);
    else t_eff = {4'd0, stacks_r};
    if (slices_r == 7'd0) s_eff = 11'd1;
    else if ({4'd0, slices_r} > 11'(MaxSlices)) s_eff = 11'(MaxSlices);
    else s_eff = {4'd0, slices_r};
  end

  // Stage 0: register the request and products for the dividers.
  logic        s0_vld_r;
  logic [6:0]  s0_i_r, s0_j_r;
  logic [10:0] s0_t_r, s0_s_r;
  logic [14:0] s0_r_r, s0_h_r;
  logic [29:0] s0_ih_r;
  logic [29:0] s0_ht_r;

  always_ff @(posedge clk) begin
    s0_vld_r <= rst_n & start;
    s0_i_r   <= in_stack_index;
    s0_j_r   <= in_slice_index;
    s0_t_r   <= t_eff;
    s0_s_r   <= s_eff;
    s0_r_r   <= radius_r;
    s0_h_r   <= height_r;
    s0_ih_r  <= 30'(in_stack_index) * 30'(height_r);
    s0_ht_r  <= 30'(height_r) * 30'(t_eff);
  end

  // Numerators. y uses an offset so the floor division sees a non-negative value.
  localparam int TagW = 1 + 7 + 7 + 11 + 15 + 1;
  logic [NW-1:0] n_phase, n_ts, n_ti, n_y;
  logic signed [NW:0] y_raw;
  logic [DW-1:0] d_s, d_t;
  logic [31:0] y_off;

  always_comb begin
    n_phase = (NW'(s0_j_r) << 33) + NW'(s0_s_r);
    n_ts    = (NW'(s0_j_r) << 17) + NW'(s0_s_r);
    n_ti    = (NW'(s0_i_r) << 17) + NW'(s0_t_r);
    // 2*i*h - h*T + T, offset by 2T*2^31 to keep it positive.
    y_off   = 32'h8000_0000;
    y_raw   = (NW+1)'({s0_ih_r, 1'b0}) - (NW+1)'(s0_ht_r) + (NW+1)'(s0_t_r)
            + (NW+1)'((NW+1)'(y_off) * (NW+1)'({s0_t_r, 1'b0}));
    n_y     = NW'(y_raw);
    d_s     = DW'({s0_s_r, 1'b0});
    d_t     = DW'({s0_t_r, 1'b0});
  end

  logic [NW-1:0] q_phase, q_ts, q_ti, q_y;
  logic [TagW-1:0] tag_p, tag_unused0, tag_unused1, tag_unused2;
  logic            quad_v0;

  assign quad_v0 = ({4'd0, s0_i_r} < s0_t_r) && ({4'd0, s0_j_r} < s0_s_r);

  cgvg_divider #(.NumW(NW), .DenW(DW), .Tag(TagW)) u_div_phase (
    .clk(clk), .rst_n(rst_n), .num(n_phase), .den(d_s),
    .tag_in({s0_vld_r, s0_i_r, s0_j_r, s0_s_r, s0_r_r, quad_v0}),
    .quo(q_phase), .tag_out(tag_p));
  cgvg_divider #(.NumW(NW), .DenW(DW), .Tag(TagW)) u_div_ts (
    .clk(clk), .rst_n(rst_n), .num(n_ts), .den(d_s), .tag_in('0), .quo(q_ts),
    .tag_out(tag_unused0));
  cgvg_divider #(.NumW(NW), .DenW(DW), .Tag(TagW)) u_div_ti (
    .clk(clk), .rst_n(rst_n), .num(n_ti), .den(d_t), .tag_in('0), .quo(q_ti),
    .tag_out(tag_unused1));
  cgvg_divider #(.NumW(NW), .DenW(DW), .Tag(TagW)) u_div_y (
    .clk(clk), .rst_n(rst_n), .num(n_y), .den(d_t), .tag_in('0), .quo(q_y),
    .tag_out(tag_unused2));

  // Unpack the tag and form side results plus the CORDIC seed.
  logic        p_vld, p_qv;
  logic [6:0]  p_i, p_j;
  logic [10:0] p_s;
  logic [14:0] p_r;
  assign {p_vld, p_i, p_j, p_s, p_r, p_qv} = tag_p;

  logic [12:0] base_idx;
  logic [19:0] base_full;
  cgvg_pkg::cgvg_cell_t seed;
  logic signed [NW:0] y_q;

  always_comb begin
    base_full = 20'(p_i) * 20'(p_s + 11'd1) + 20'(p_j);
    base_idx  = base_full[12:0];
    y_q       = $signed({1'b0, q_y}) - (NW+1)'(33'sh80000000);
    seed.vld  = p_vld;
    seed.x    = CW'(cgvg_pkg::CordicGain);
    seed.y    = '0;
    seed.z    = {4'd0, q_phase[29:0]};
    seed.quad = q_phase[31:30];
    seed.radius = p_r;
    if (y_q > 32767) seed.pos_y = 16'sh7FFF;
    else if (y_q < -32768) seed.pos_y = -16'sh8000;
    else seed.pos_y = y_q[15:0];
    seed.tex_s  = (q_ts > NW'(65536)) ? 17'd65536 : q_ts[16:0];
    seed.tex_t  = (q_ti >= NW'(65536)) ? 17'd0 : 17'(NW'(65536) - q_ti);
    seed.quad_valid = p_qv;
    seed.base    = base_idx;
    seed.s_plus1 = 13'(p_s) + 13'd1;
  end

  // Chain of CORDIC cells.
  cgvg_pkg::cgvg_cell_t chain [cgvg_pkg::CordicSteps+1];
  assign chain[0] = seed;
  for (genvar k = 0; k < cgvg_pkg::CordicSteps; k++) begin : g_cell
    cgvg_cell #(.Step(k)) u_cell (
      .cgvg_clk(clk), .cgvg_rst_n(rst_n), .d_in(chain[k]), .d_out(chain[k+1]));
  end

  // Quadrant map and rounding to Q1.15.
  cgvg_pkg::cgvg_cell_t e1_r, e1_nxt;
  logic signed [CW-1:0] c_full, s_full;
  logic signed [CW-1:0] c_rnd, s_rnd;
  logic signed [15:0]   cos_q, sin_q;
  logic signed [15:0]   cos_r, sin_r;
  always_comb begin
    e1_nxt     = chain[cgvg_pkg::CordicSteps];
    e1_nxt.vld = chain[cgvg_pkg::CordicSteps].vld & rst_n;
    unique case (chain[cgvg_pkg::CordicSteps].quad)
      2'd0: begin c_full = chain[cgvg_pkg::CordicSteps].x;
                  s_full = chain[cgvg_pkg::CordicSteps].y; end
      2'd1: begin c_full = -chain[cgvg_pkg::CordicSteps].y;
                  s_full = chain[cgvg_pkg::CordicSteps].x; end
      2'd2: begin c_full = -chain[cgvg_pkg::CordicSteps].x;
                  s_full = -chain[cgvg_pkg::CordicSteps].y; end
      default: begin c_full = chain[cgvg_pkg::CordicSteps].y;
                     s_full = -chain[cgvg_pkg::CordicSteps].x; end
    endcase
    c_rnd = (c_full + CW'(16384)) >>> 15;
    s_rnd = (s_full + CW'(16384)) >>> 15;
    cos_q = (c_rnd > 32767) ? 16'sd32767 : (c_rnd < -32767) ? -16'sd32767 : c_rnd[15:0];
    sin_q = (s_rnd > 32767) ? 16'sd32767 : (s_rnd < -32767) ? -16'sd32767 : s_rnd[15:0];
  end

  always_ff @(posedge clk) begin
    e1_r  <= e1_nxt;
    cos_r <= cos_q;
    sin_r <= sin_q;
  end

  // Scale by radius.
  cgvg_pkg::cgvg_cell_t e2_r, e2_nxt;
  logic signed [31:0] mx_r, mz_r;
  always_comb begin
    e2_nxt     = e1_r;
    e2_nxt.vld = e1_r.vld & rst_n;
  end

  always_ff @(posedge clk) begin
    e2_r <= e2_nxt;
    mx_r <= -($signed({17'd0, e1_r.radius}) * 32'(sin_r));
    mz_r <= $signed({17'd0, e1_r.radius}) * 32'(cos_r);
  end

  // Round, saturate and register the result.
  logic signed [31:0] x_rnd, z_rnd;
  logic signed [15:0] x_sat, z_sat;
  always_comb begin
    x_rnd = (mx_r + 32'sd16384) >>> 15;
    z_rnd = (mz_r + 32'sd16384) >>> 15;
    x_sat = (x_rnd > 32767) ? 16'sh7FFF : (x_rnd < -32768) ? -16'sh8000 : x_rnd[15:0];
    z_sat = (z_rnd > 32767) ? 16'sh7FFF : (z_rnd < -32768) ? -16'sh8000 : z_rnd[15:0];
  end

  always_ff @(posedge clk) begin
    out_valid      <= rst_n & e2_r.vld;
    out_pos_x      <= x_sat;
    out_pos_y      <= e2_r.pos_y;
    out_pos_z      <= z_sat;
    out_tex_s      <= e2_r.tex_s;
    out_tex_t      <= e2_r.tex_t;
    out_quad_valid <= e2_r.quad_valid;
    out_tri0_a     <= e2_r.quad_valid ? e2_r.base + e2_r.s_plus1 : '0;
    out_tri0_b     <= e2_r.quad_valid ? e2_r.base + e2_r.s_plus1 + 13'd1 : '0;
    out_tri0_c     <= e2_r.quad_valid ? e2_r.base : '0;
    out_tri1_a     <= e2_r.quad_valid ? e2_r.base + 13'd1 : '0;
    out_tri1_b     <= e2_r.quad_valid ? e2_r.base : '0;
    out_tri1_c     <= e2_r.quad_valid ? e2_r.base + e2_r.s_plus1 + 13'd1 : '0;
  end

endmodule

// ----- design/cgvg_checker.sv -----
// Port-level checks on the vertex generator.
module cgvg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_quad_valid,
  input logic [12:0] out_tri0_c,
  input logic [12:0] out_tri1_b,
  input logic [12:0] out_tri0_b,
  input logic [12:0] out_tri1_c,
  input logic [16:0] out_tex_s,
  input logic [16:0] out_tex_t
);

  // The block always takes a request.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Shared corners of the two triangles agree.
  a_shared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tri0_c == out_tri1_b) && (out_tri0_b == out_tri1_c))
    else $error("triangle corners differ");

  // Unused quads carry a zero tri0_c index.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_quad_valid) |-> (out_tri0_c == 13'd0))
    else $error("unused quad index not zero");

  // Texture coordinates stay within one.
  a_tex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tex_s <= 17'd65536) && (out_tex_t <= 17'd65536))
    else $error("texture coordinate out of range");

endmodule

bind cylinder_grid_vertex_generator cgvg_checker u_cgvg_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_quad_valid(out_quad_valid), .out_tri0_c(out_tri0_c), .out_tri1_b(out_tri1_b),
  .out_tri0_b(out_tri0_b), .out_tri1_c(out_tri1_c), .out_tex_s(out_tex_s),
  .out_tex_t(out_tex_t));

// ----- tb/cgvg_checker.sv -----
// Watches the request and result channels of the vertex generator, predicts
// each vertex from the current register settings and compares field by field.
module cgvg_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [6:0]         in_stack_index,
  input  logic [6:0]         in_slice_index,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               out_valid,
  input  logic signed [15:0] out_pos_x,
  input  logic signed [15:0] out_pos_y,
  input  logic signed [15:0] out_pos_z,
  input  logic [16:0]        out_tex_s,
  input  logic [16:0]        out_tex_t,
  input  logic               out_quad_valid,
  input  logic [12:0]        out_tri0_a,
  input  logic [12:0]        out_tri0_b,
  input  logic [12:0]        out_tri0_c,
  input  logic [12:0]        out_tri1_a,
  input  logic [12:0]        out_tri1_b,
  input  logic [12:0]        out_tri1_c,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [16:0]        ts;
    logic [16:0]        tt;
    logic               qv;
    logic [12:0]        a0, b0, c0, a1, b1, c1;
  } vertex_t;

  vertex_t    vertex_q[$];
  logic [14:0] radius_r, height_r;
  logic [6:0]  stacks_r, slices_r;

  // Arithmetic shift right equals floor division by a power of two.
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint turn_atan(int k);
    longint tab[16];
    tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    return tab[k];
  endfunction

  // Vertex prediction for grid point (i, j) under the current registers.
  function automatic vertex_t grid_vertex(longint i, longint j);
    vertex_t v;
    longint t, s, r, h, x, y, z, dx, dy, c, sn, cs, ti, ts, base;
    logic [31:0] phase;
    t = (stacks_r == 0) ? 1 : (stacks_r > 64 ? 64 : stacks_r);
    s = (slices_r == 0) ? 1 : (slices_r > 64 ? 64 : slices_r);
    r = radius_r;
    h = height_r;
    phase = 32'(floor_div((j << 33) + s, 2 * s));
    x = 652032874;
    y = 0;
    z = phase[29:0];
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= turn_atan(k);
      end else begin
        x += dx; y -= dy; z += turn_atan(k);
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  sn = y;  end
      2'd1: begin c = -y; sn = x;  end
      2'd2: begin c = -x; sn = -y; end
      default: begin c = y; sn = -x; end
    endcase
    cs = clamp((c + 16384) >>> 15, -32767, 32767);
    sn = clamp((sn + 16384) >>> 15, -32767, 32767);
    v.px = 16'(clamp((-r * sn + 16384) >>> 15, -32768, 32767));
    v.pz = 16'(clamp((r * cs + 16384) >>> 15, -32768, 32767));
    v.py = 16'(clamp(floor_div(2 * i * h - h * t + t, 2 * t), -32768, 32767));
    ts = floor_div(2 * j * 65536 + s, 2 * s);
    v.ts = 17'(ts > 65536 ? 65536 : ts);
    ti = floor_div(2 * i * 65536 + t, 2 * t);
    v.tt = 17'(ti >= 65536 ? 0 : 65536 - ti);
    v.qv = (i < t) && (j < s);
    base = i * (s + 1) + j;
    if (v.qv) begin
      v.a0 = 13'(base + s + 1); v.b0 = 13'(base + s + 2); v.c0 = 13'(base);
      v.a1 = 13'(base + 1);     v.b1 = 13'(base);         v.c1 = 13'(base + s + 2);
    end else begin
      {v.a0, v.b0, v.c0, v.a1, v.b1, v.c1} = '0;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending_count = vertex_q.size();

  always @(posedge clk) begin
    vertex_t want;
    if (!rst_n) begin
      radius_r <= 15'd256;
      height_r <= 15'd256;
      stacks_r <= 7'd8;
      slices_r <= 7'd16;
    end else begin
      if (start && !busy) vertex_q.push_back(grid_vertex(in_stack_index, in_slice_index));
      if (out_valid) begin
        if (vertex_q.size() == 0) begin
          report_mismatch("unexpected vertex", 1, 0);
        end else begin
          want = vertex_q.pop_front();
          if (out_pos_x != want.px) report_mismatch("pos_x", out_pos_x, want.px);
          if (out_pos_y != want.py) report_mismatch("pos_y", out_pos_y, want.py);
          if (out_pos_z != want.pz) report_mismatch("pos_z", out_pos_z, want.pz);
          if (out_tex_s != want.ts) report_mismatch("tex_s", out_tex_s, want.ts);
          if (out_tex_t != want.tt) report_mismatch("tex_t", out_tex_t, want.tt);
          if (out_quad_valid != want.qv) report_mismatch("quad_valid", out_quad_valid, want.qv);
          if (out_tri0_a != want.a0) report_mismatch("tri0_a", out_tri0_a, want.a0);
          if (out_tri0_b != want.b0) report_mismatch("tri0_b", out_tri0_b, want.b0);
          if (out_tri0_c != want.c0) report_mismatch("tri0_c", out_tri0_c, want.c0);
          if (out_tri1_a != want.a1) report_mismatch("tri1_a", out_tri1_a, want.a1);
          if (out_tri1_b != want.b1) report_mismatch("tri1_b", out_tri1_b, want.b1);
          if (out_tri1_c != want.c1) report_mismatch("tri1_c", out_tri1_c, want.c1);
        end
      end
      // Register writes take effect for requests after this edge.
      if (cfg_we) begin
        case (cgvg_pkg::cfg_reg_t'(cfg_index))
          cgvg_pkg::REG_RADIUS: radius_r <= cfg_data;
          cgvg_pkg::REG_HEIGHT: height_r <= cfg_data;
          cgvg_pkg::REG_STACKS: stacks_r <= cfg_data[6:0];
          cgvg_pkg::REG_SLICES: slices_r <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Drives grid-point requests and register settings into the vertex generator.
module tb_top;

  localparam int DrainCycles = 120;
  localparam int WatchLimit  = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [6:0] in_stack_index = '0;
  logic [6:0] in_slice_index = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic out_valid, out_quad_valid;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic [16:0] out_tex_s, out_tex_t;
  logic [12:0] out_tri0_a, out_tri0_b, out_tri0_c, out_tri1_a, out_tri1_b, out_tri1_c;
  int fail_count, pending_count, idle_cycles;

  always #2 clk = ~clk;

  cylinder_grid_vertex_generator i_dut (.*);
  cgvg_scoreboard i_checker (.*);

  // Watchdog: counts cycles in which no request or result moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("cylinder_grid_vertex_generator test failed");
      $finish;
    end
  end

  task automatic write_reg(cgvg_pkg::cfg_reg_t idx, logic [14:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Waits until all vertices are back and the pipeline has emptied.
  task automatic drain();
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Presents one request, keeping start high when the next follows at once.
  task automatic send_point(logic [6:0] i, logic [6:0] j, bit gaps);
    int gap;
    in_stack_index = i;
    in_slice_index = j;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = 0;
    if (gaps) gap = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(2);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic settle_point();
    start = 1'b0;
  endtask

  task automatic set_shape(logic [14:0] r, logic [14:0] h, logic [6:0] t, logic [6:0] s);
    drain();
    write_reg(cgvg_pkg::REG_RADIUS, r);
    write_reg(cgvg_pkg::REG_HEIGHT, h);
    write_reg(cgvg_pkg::REG_STACKS, {8'd0, t});
    write_reg(cgvg_pkg::REG_SLICES, {8'd0, s});
  endtask

  initial begin
    int t, s;
    bit gaps;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed points at reset settings: corners, seam and beyond-count indices.
    send_point(0, 0, 0);
    send_point(8, 16, 0);
    send_point(7, 15, 0);
    send_point(4, 4, 0);
    send_point(127, 127, 0);
    send_point(0, 8, 0);
    send_point(9, 17, 0);
    settle_point();

    // Largest shape with extreme indices and saturating positions.
    set_shape(15'h7FFF, 15'h7FFF, 7'd64, 7'd64);
    send_point(64, 64, 0);
    send_point(63, 63, 0);
    send_point(127, 127, 0);
    send_point(0, 16, 0);
    send_point(0, 48, 0);
    send_point(32, 32, 0);
    settle_point();

    // Zero counts act as one; counts above the maximum saturate.
    set_shape(15'd0, 15'd0, 7'd0, 7'd127);
    send_point(0, 0, 0);
    send_point(1, 64, 0);
    send_point(85, 42, 0);
    send_point(0, 65, 0);
    settle_point();
    set_shape(15'd1, 15'd1, 7'd1, 7'd1);
    send_point(0, 0, 0);
    send_point(1, 1, 0);
    send_point(42, 85, 0);
    settle_point();

    // Random phases, each with its own shape; mostly in-grid points.
    for (int ph = 0; ph < 14; ph++) begin
      t = $urandom_range(127);
      s = $urandom_range(127);
      if (ph % 3 == 0) begin
        t = $urandom_range(1, 64);
        s = $urandom_range(1, 64);
      end
      set_shape(15'($urandom_range(15'h7FFF)), 15'($urandom_range(15'h7FFF)),
                7'(t), 7'(s));
      // Unknown register indexes cannot be addressed by the two-bit port.
      gaps = (ph % 4) != 1;
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(7) == 0)
          send_point(7'($urandom_range(127)), 7'($urandom_range(127)), gaps);
        else
          send_point(7'($urandom_range(t > 64 ? 64 : (t == 0 ? 1 : t))),
                     7'($urandom_range(s > 64 ? 64 : (s == 0 ? 1 : s))), gaps);
      end
      settle_point();
    end

    drain();
    if (fail_count == 0) begin
      $display("cylinder_grid_vertex_generator test passed");
    end else begin
      $display("cylinder_grid_vertex_generator test failed");
    end
    $finish;
  end
endmodule
